// ===== hdl/stq_pkg.sv =====
// ----------------------------------------------------------------------------
// stq_pkg
// Shared types and codes of the sorted timer queue: operation and status
// codes, the cell command set and the word that a cell shows its neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

package stq_pkg;

  localparam int IdW   = 16;
  localparam int TimeW = 32;
  localparam int StW   = 3;
  localparam int OccW  = 6;

  // Operation codes of an input word
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_ADJUST = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_TICK   = 2'd3;

  // Status codes of a result word
  localparam logic [StW-1:0] ST_DONE    = 3'd0;
  localparam logic [StW-1:0] ST_FULL    = 3'd1;
  localparam logic [StW-1:0] ST_MISSING = 3'd2;
  localparam logic [StW-1:0] ST_FIRED   = 3'd3;
  localparam logic [StW-1:0] ST_NONE    = 3'd4;

  // Command broadcast to every cell of the row
  typedef enum logic [2:0] {
    CELL_NOP,
    CELL_CMP_ADD,
    CELL_CMP_ID,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_WRITE,
    CELL_POP
  } cell_cmd_e;

  // What a cell shows to its neighbors
  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [TimeW-1:0] expiry;
    logic             lt;
    logic             used;
  } cell_data_t;

endpackage

`default_nettype wire

// ===== hdl/stq_cell.sv =====
// ----------------------------------------------------------------------------
// stq_cell
// One slot of the sorted row. Holds one timer, compares it against the key
// and shifts toward or away from the head together with its neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module stq_cell
  import stq_pkg::*;
#(
  parameter int IDX = 0,
  parameter int CW  = 6
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cell_cmd_e        cmd_i,
  input  wire logic [IdW-1:0]   key_id_i,
  input  wire logic [TimeW-1:0] key_exp_i,
  input  wire logic [CW-1:0]    count_i,
  input  wire cell_data_t       prev_i,
  input  wire cell_data_t       next_i,
  input  wire logic             before_i,
  output logic                  before_o,
  output logic                  reloc_o,
  output cell_data_t            data_o
);

  localparam logic [CW-1:0] IdxC = CW'(IDX);

  logic [IdW-1:0]   id_q, id_d;
  logic [TimeW-1:0] exp_q, exp_d;
  logic             flag_q, flag_d;
  logic             lt_q, lt_d;
  logic             used;
  logic             at_end;
  logic             key_lt;
  logic             hit;

  assign used    = count_i > IdxC;
  assign at_end  = count_i == IdxC;
  assign key_lt  = key_exp_i < exp_q;
  assign hit     = flag_q & ~before_i;
  assign before_o = before_i | flag_q;
  // Flag an adjust whose successor is not strictly later
  assign reloc_o = hit & next_i.used & ~next_i.lt;

  assign data_o.id     = id_q;
  assign data_o.expiry = exp_q;
  assign data_o.lt     = lt_q;
  assign data_o.used   = used;

  // Compare, shift or load under the broadcast command
  always_comb begin
    id_d   = id_q;
    exp_d  = exp_q;
    flag_d = flag_q;
    lt_d   = lt_q;
    unique case (cmd_i)
      CELL_NOP: begin
      end
      CELL_CMP_ADD: begin
        lt_d   = key_lt;
        flag_d = used ? key_lt : at_end;
      end
      CELL_CMP_ID: begin
        lt_d   = key_lt;
        flag_d = used & (key_id_i == id_q);
      end
      CELL_INSERT: begin
        if (before_i) begin
          id_d  = prev_i.id;
          exp_d = prev_i.expiry;
        end else if (flag_q) begin
          id_d  = key_id_i;
          exp_d = key_exp_i;
        end
      end
      CELL_REMOVE: begin
        if (before_i | flag_q) begin
          id_d  = next_i.id;
          exp_d = next_i.expiry;
        end
      end
      CELL_WRITE: begin
        if (hit) begin
          exp_d = key_exp_i;
        end
      end
      CELL_POP: begin
        id_d  = next_i.id;
        exp_d = next_i.expiry;
      end
      default: begin
      end
    endcase
  end

  // Hold the compare flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b0;
      lt_q   <= 1'b0;
    end else begin
      flag_q <= flag_d;
      lt_q   <= lt_d;
    end
  end

  // Hold the timer itself
  always_ff @(posedge clk_i) begin
    id_q  <= id_d;
    exp_q <= exp_d;
  end

endmodule

`default_nettype wire

// ===== hdl/sorted_timer_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_timer_queue
// Up to DEPTH timers kept in a row of cells ordered by expiry. Add, adjust,
// delete and tick act on the row by broadcast compare and neighbor shifts.
// ----------------------------------------------------------------------------
//  Channel  Handshake                 Word
//  in       in_valid_i / in_stall_o   operation, timer_id, expire_time,
//                                     current_time
//  out      out_valid_o / out_stall_i status, fired_id, fired_expiry, last,
//                                     occupancy
//
//  Add, delete and adjust in place go from accept to the result register
//  through accept, compare in all cells, shift or write, result load.
//  An adjust that moves its entry removes it, compares again and inserts.
//  A tick loads one result word per popped entry; the row pops one entry
//  per cycle while the output is not stalled. A full add goes to the result.
//  One word is worked at a time; in_stall_o is high while it is in work.
//  A stalled output holds its word and pauses the worker. No clear pass.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_timer_queue
  import stq_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [1:0]       operation_i,
  input  wire logic [IdW-1:0]   timer_id_i,
  input  wire logic [TimeW-1:0] expire_time_i,
  input  wire logic [TimeW-1:0] current_time_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [StW-1:0]        status_o,
  output logic [IdW-1:0]        fired_id_o,
  output logic [TimeW-1:0]      fired_expiry_o,
  output logic                  last_o,
  output logic [OccW-1:0]       occupancy_o
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);
  localparam logic [CW-1:0] OneC   = CW'(1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CMP    = 3'd1;
  localparam logic [2:0] S_APPLY  = 3'd2;
  localparam logic [2:0] S_RECMP  = 3'd3;
  localparam logic [2:0] S_REINS  = 3'd4;
  localparam logic [2:0] S_RESULT = 3'd5;
  localparam logic [2:0] S_TICK   = 3'd6;

  logic [2:0]       state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic [1:0]       op_q;
  logic [IdW-1:0]   key_id_q;
  logic [TimeW-1:0] key_exp_q;
  logic [TimeW-1:0] key_now_q;
  logic [StW-1:0]   pend_q, pend_d;

  logic             out_valid_q;
  logic [StW-1:0]   status_q, ld_status;
  logic [IdW-1:0]   fid_q, ld_fid;
  logic [TimeW-1:0] fexp_q, ld_fexp;
  logic             last_q, ld_last;
  logic [OccW-1:0]  occ_q, ld_occ;
  logic             out_load;
  logic             out_free;

  logic             in_acc;
  cell_cmd_e        cmd;
  cell_data_t       cdata [DEPTH];
  logic [DEPTH:0]   bchain;
  logic [DEPTH-1:0] reloc_v;
  logic             found;
  logic             reloc;
  logic             due;
  logic             fin;

  assign in_stall_o = state_q != S_IDLE;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign out_free   = ~out_valid_q | ~out_stall_i;

  // Row of cells with the first-hit chain rippling toward the tail
  assign bchain[0] = 1'b0;
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    cell_data_t prev_w;
    cell_data_t next_w;
    if (g == 0) begin : g_head
      assign prev_w = '0;
    end else begin : g_mid
      assign prev_w = cdata[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign next_w = '0;
    end else begin : g_body
      assign next_w = cdata[g+1];
    end
    stq_cell #(
      .IDX(g),
      .CW (CW)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .cmd_i    (cmd),
      .key_id_i (key_id_q),
      .key_exp_i(key_exp_q),
      .count_i  (count_q),
      .prev_i   (prev_w),
      .next_i   (next_w),
      .before_i (bchain[g]),
      .before_o (bchain[g+1]),
      .reloc_o  (reloc_v[g]),
      .data_o   (cdata[g])
    );
  end

  assign found = bchain[DEPTH];
  assign reloc = |reloc_v;
  // Head expired, and whether the one behind it stops the tick
  assign due   = (count_q != '0) & ~(key_now_q < cdata[0].expiry);
  assign fin   = (count_q == OneC) | (key_now_q < cdata[1].expiry);

  // Sequence one word through the row
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    pend_d    = pend_q;
    cmd       = CELL_NOP;
    out_load  = 1'b0;
    ld_status = ST_DONE;
    ld_fid    = '0;
    ld_fexp   = '0;
    ld_last   = 1'b1;
    ld_occ    = OccW'(count_q);
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (operation_i == OP_TICK) begin
            state_d = S_TICK;
          end else if (operation_i == OP_ADD && count_q == DepthC) begin
            pend_d  = ST_FULL;
            state_d = S_RESULT;
          end else begin
            state_d = S_CMP;
          end
        end
      end
      S_CMP: begin
        cmd     = (op_q == OP_ADD) ? CELL_CMP_ADD : CELL_CMP_ID;
        state_d = S_APPLY;
      end
      S_APPLY: begin
        pend_d  = ST_DONE;
        state_d = S_RESULT;
        if (op_q == OP_ADD) begin
          cmd     = CELL_INSERT;
          count_d = count_q + OneC;
        end else if (!found) begin
          pend_d = ST_MISSING;
        end else if (op_q == OP_DELETE) begin
          cmd     = CELL_REMOVE;
          count_d = count_q - OneC;
        end else if (reloc) begin
          cmd     = CELL_REMOVE;
          count_d = count_q - OneC;
          state_d = S_RECMP;
        end else begin
          cmd = CELL_WRITE;
        end
      end
      S_RECMP: begin
        cmd     = CELL_CMP_ADD;
        state_d = S_REINS;
      end
      S_REINS: begin
        cmd     = CELL_INSERT;
        count_d = count_q + OneC;
        state_d = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          out_load  = 1'b1;
          ld_status = pend_q;
          state_d   = S_IDLE;
        end
      end
      S_TICK: begin
        if (out_free) begin
          out_load = 1'b1;
          if (due) begin
            cmd       = CELL_POP;
            count_d   = count_q - OneC;
            ld_status = ST_FIRED;
            ld_fid    = cdata[0].id;
            ld_fexp   = cdata[0].expiry;
            ld_last   = fin;
            ld_occ    = OccW'(count_d);
            if (fin) begin
              state_d = S_IDLE;
            end
          end else begin
            ld_status = ST_NONE;
            state_d   = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Advance control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the input word and the result word
  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    if (in_acc) begin
      op_q      <= operation_i;
      key_id_q  <= timer_id_i;
      key_exp_q <= expire_time_i;
      key_now_q <= current_time_i;
    end
    if (out_load) begin
      status_q <= ld_status;
      fid_q    <= ld_fid;
      fexp_q   <= ld_fexp;
      last_q   <= ld_last;
      occ_q    <= ld_occ;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign fired_id_o     = fid_q;
  assign fired_expiry_o = fexp_q;
  assign last_o         = last_q;
  assign occupancy_o    = occ_q;

  // The fill never exceeds the row
  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC)
    else $error("timer count above depth");

  // The fill moves by at most one per cycle
  a_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 (count_q == $past(count_q) || count_q == $past(count_q) + OneC ||
         count_q == $past(count_q) - OneC))
    else $error("timer count jumped");

  // A full answer only comes from a full row
  a_full_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && ld_status == ST_FULL |-> count_q == DepthC)
    else $error("full status with free slots");

  // A pop only happens on a fired result
  a_pop_fired : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd == CELL_POP |-> out_load && ld_status == ST_FIRED)
    else $error("pop without fired result");

endmodule

`default_nettype wire
